// ===== hw/rtl/shecc_pkg.sv =====
// Shared types, codes and Hamming(13,8) SECDED helper functions.
package shecc_pkg;

    localparam int DEPTH  = 1024;
    localparam int RAM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W = 13;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_READ   = 2'd1,
        REQ_INJECT = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_PARITY = 2'd1,
        STAT_DOUBLE = 2'd2,
        STAT_SINGLE = 2'd3
    } status_t;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

    // Stored codeword: chk[0] c1, chk[1] c2, chk[2] c4, chk[3] c8, chk[4] overall parity
    typedef struct packed {
        logic [4:0] chk;
        logic [7:0] data;
    } word_t;

    // Decoder verdict for one stored word
    typedef struct packed {
        status_t    status;
        logic [3:0] pos;
        logic       repair;
        logic [4:0] chk;
    } dec_t;

    // Four Hamming check bits plus overall parity
    function automatic logic [4:0] encode(input logic [7:0] d);
        logic c1;
        logic c2;
        logic c4;
        logic c8;
        c1 = d[0] ^ d[1] ^ d[3] ^ d[4] ^ d[6];
        c2 = d[0] ^ d[2] ^ d[3] ^ d[5] ^ d[6];
        c4 = d[1] ^ d[2] ^ d[3] ^ d[7];
        c8 = d[4] ^ d[5] ^ d[6] ^ d[7];
        return {(^d) ^ c1 ^ c2 ^ c4 ^ c8, c8, c4, c2, c1};
    endfunction

    // Flip codeword positions selected by the mask (bit 0 is overall parity)
    function automatic word_t inject(input word_t w, input logic [12:0] mask);
        word_t r;
        r.data = w.data ^ {mask[12], mask[11], mask[10], mask[9],
                           mask[7], mask[6], mask[5], mask[3]};
        r.chk  = w.chk ^ {mask[0], mask[8], mask[4], mask[2], mask[1]};
        return r;
    endfunction

endpackage

// ===== hw/rtl/shecc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module shecc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/shecc_decode.sv =====
// Syndrome and overall parity check of one stored codeword.
module shecc_decode (
    input  shecc_pkg::word_t word,
    output shecc_pkg::dec_t  dec
);

    logic [4:0] enc;
    logic [3:0] syn;
    logic       pw;
    logic       pw2;

    // Form syndrome and recomputed overall parity
    always_comb
    begin
        enc = shecc_pkg::encode(word.data);
        syn = enc[3:0] ^ word.chk[3:0];
        pw  = word.chk[4];
        pw2 = (^word.data) ^ (^word.chk[3:0]);
    end

    // Classify the error
    always_comb
    begin
        dec.status = shecc_pkg::STAT_OK;
        dec.pos    = 4'd0;
        dec.repair = 1'b0;
        dec.chk    = {pw2, word.chk[3:0]};
        if (syn == 4'd0)
        begin
            if (pw != pw2)
            begin
                dec.status = shecc_pkg::STAT_PARITY;
                dec.repair = 1'b1;
            end
        end
        else if ((pw == pw2) || (syn inside {[4'd13:4'd15]}))
        begin
            dec.status = shecc_pkg::STAT_DOUBLE;
        end
        else
        begin
            dec.status = shecc_pkg::STAT_SINGLE;
            dec.pos    = syn;
        end
    end

endmodule

// ===== hw/rtl/secded_hamming_ecc_memory_core.sv =====
// Top level of the SECDED Hamming(13,8) protected byte memory.
//
// A 1024 x 13-bit codeword memory with write, read-and-check and fault-inject
// requests. A request is taken when start is high and busy is low; one request
// can be taken every cycle. Its result appears on read_data, status and
// error_position with done high for exactly one cycle, after the stage 1 and result
// registers; the receiver cannot stall it, so it must capture it then.
// Each request reads the RAM (registered read port), checks or modifies the
// word, and writes it back in the following cycle; a request to the same
// location as the one just before it takes the freshly written word from a
// bypass register. After reset, busy stays high while a sweep clears the
// memory one location per cycle.
module secded_hamming_ecc_memory_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [9:0]  address,
    input  logic [7:0]  write_data,
    input  logic [12:0] flip_mask,
    output logic        done,
    output logic [7:0]  read_data,
    output logic [1:0]  status,
    output logic [3:0]  error_position
);

    localparam int AW = shecc_pkg::RAM_AW;

    shecc_pkg::state_t state_reg;
    shecc_pkg::state_t state_next;
    logic [AW-1:0]     clr_cnt_reg;
    logic [AW-1:0]     clr_cnt_next;
    logic              clr_we;

    logic              accept;
    logic              s1_valid_reg;
    logic              s1_ok_reg;
    logic [1:0]        s1_req_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic [7:0]        s1_wdata_reg;
    logic [12:0]       s1_mask_reg;

    logic              wb_valid_reg;
    logic [AW-1:0]     wb_addr_reg;
    shecc_pkg::word_t  wb_word_reg;

    logic [shecc_pkg::WORD_W-1:0] ram_q;
    shecc_pkg::word_t  cur_word;
    shecc_pkg::dec_t   dec;

    logic              wr_en;
    shecc_pkg::word_t  wr_word;
    logic [7:0]        res_data;
    shecc_pkg::status_t res_status;
    logic [3:0]        res_pos;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [shecc_pkg::WORD_W-1:0] ram_wdata;

    logic              done_reg;
    logic [7:0]        read_data_reg;
    shecc_pkg::status_t status_reg;
    logic [3:0]        error_position_reg;

    // Clearing sweep: next state
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            shecc_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(shecc_pkg::DEPTH - 1))
                begin
                    state_next = shecc_pkg::ST_RUN;
                end
            end
            shecc_pkg::ST_RUN:
            begin
                state_next = shecc_pkg::ST_RUN;
            end
            default:
            begin
                state_next = shecc_pkg::ST_CLEAR;
            end
        endcase
    end

    // Clearing sweep: outputs
    always_comb
    begin
        busy   = 1'b0;
        clr_we = 1'b0;
        case (state_reg)
            shecc_pkg::ST_CLEAR:
            begin
                busy   = 1'b1;
                clr_we = 1'b1;
            end
            shecc_pkg::ST_RUN:
            begin
                busy   = 1'b0;
                clr_we = 1'b0;
            end
            default:
            begin
                busy   = 1'b1;
                clr_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= shecc_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign accept = start && !busy;

    // Stage 1: hold the request while its word is read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ok_reg    <= (32'(address) < shecc_pkg::DEPTH);
            s1_req_reg   <= req_type;
            s1_addr_reg  <= AW'(address);
            s1_wdata_reg <= write_data;
            s1_mask_reg  <= flip_mask;
        end
    end

    shecc_ram #(
        .WIDTH (shecc_pkg::WORD_W),
        .DEPTH (shecc_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (AW'(address)),
        .rdata (ram_q)
    );

    // Bypass the word written back in the previous cycle
    assign cur_word = (wb_valid_reg && (wb_addr_reg == s1_addr_reg)) ? wb_word_reg
                                                                    : shecc_pkg::word_t'(ram_q);

    shecc_decode u_decode (
        .word (cur_word),
        .dec  (dec)
    );

    // Modify the word and form the result
    always_comb
    begin
        wr_en      = 1'b0;
        wr_word    = cur_word;
        res_data   = 8'd0;
        res_status = shecc_pkg::STAT_OK;
        res_pos    = 4'd0;
        if (s1_valid_reg && s1_ok_reg)
        begin
            case (s1_req_reg)
                shecc_pkg::REQ_WRITE:
                begin
                    wr_en        = 1'b1;
                    wr_word.data = s1_wdata_reg;
                    wr_word.chk  = shecc_pkg::encode(s1_wdata_reg);
                end
                shecc_pkg::REQ_READ:
                begin
                    res_data   = cur_word.data;
                    res_status = dec.status;
                    res_pos    = dec.pos;
                    if (dec.repair)
                    begin
                        wr_en       = 1'b1;
                        wr_word.chk = dec.chk;
                    end
                end
                shecc_pkg::REQ_INJECT:
                begin
                    wr_en   = 1'b1;
                    wr_word = shecc_pkg::inject(cur_word, s1_mask_reg);
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // Write port: clearing sweep or write-back
    always_comb
    begin
        ram_we    = clr_we || wr_en;
        ram_waddr = clr_we ? clr_cnt_reg : s1_addr_reg;
        ram_wdata = clr_we ? '0 : wr_word;
    end

    // Track the last write-back for the bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wb_addr_reg <= s1_addr_reg;
            wb_word_reg <= wr_word;
        end
    end

    // Result register: one-cycle strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            read_data_reg      <= res_data;
            status_reg         <= res_status;
            error_position_reg <= res_pos;
        end
    end

    assign done           = done_reg;
    assign read_data      = read_data_reg;
    assign status         = status_reg;
    assign error_position = error_position_reg;

    // Every result has a matching accepted request, through stage 1 and the result register
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a matching request");

    // A position is only reported with a single-bit error
    a_pos_single: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != shecc_pkg::STAT_SINGLE)) |-> (error_position == 4'd0))
        else $error("error position reported without single-bit status");

    // Data is returned only for reads
    a_data_read: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (read_data != 8'd0)) |-> ($past(s1_req_reg) == shecc_pkg::REQ_READ))
        else $error("read data on a non-read request");

    // No request is in flight during the clearing sweep
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s1_valid_reg)
        else $error("request in flight while clearing");

endmodule

// ===== dv/tb_secded_hamming_ecc_memory_core.sv =====
`timescale 1ns / 100ps
// Testbench for the SECDED Hamming(13,8) protected byte memory core.
module tb_secded_hamming_ecc_memory_core;
    import shecc_pkg::*;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 750;
    localparam int         STALL_LIMIT  = 4000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         NUM_ROWS     = 26;

    // Expected outcome of one request
    typedef struct packed {
        logic [7:0] data;
        status_t    status;
        logic [3:0] pos;
    } verdict_t;

    // One row of directed stimulus; typed rows carry their own expectation
    typedef struct packed {
        logic [1:0]  req;
        logic [9:0]  addr;
        logic [7:0]  wdata;
        logic [12:0] mask;
        logic        typed;
        logic [7:0]  exp_data;
        logic [1:0]  exp_status;
        logic [3:0]  exp_pos;
    } access_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [9:0]  address;
    logic [7:0]  write_data;
    logic [12:0] flip_mask;
    logic        done;
    logic [7:0]  read_data;
    logic [1:0]  status;
    logic [3:0]  error_position;

    logic [12:0]  codeword_mem [DEPTH];
    verdict_t     pending_verdicts [$];
    access_row_t  directed_rows [NUM_ROWS];
    logic [9:0]   hot_addrs [8];
    int           err_count = 0;
    int           issued = 0;
    bit           burst_mode = 1'b0;

    secded_hamming_ecc_memory_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .address        (address),
        .write_data     (write_data),
        .flip_mask      (flip_mask),
        .done           (done),
        .read_data      (read_data),
        .status         (status),
        .error_position (error_position)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // XOR of the positions of all set bits, overall parity excluded
    function automatic logic [3:0] syndrome_of(input logic [12:0] cw);
        logic [3:0] s;
        int         k;
        s = 4'd0;
        for (k = 1; k < 13; k++)
        begin
            if (cw[k])
                s ^= k[3:0];
        end
        return s;
    endfunction

    // Place data bits, then pick check bits that cancel the syndrome
    function automatic logic [12:0] build_codeword(input logic [7:0] d);
        logic [12:0] cw;
        logic [3:0]  s;
        cw = {d[7:4], 1'b0, d[3:1], 1'b0, d[0], 3'b000};
        s  = syndrome_of(cw);
        cw[1]  = s[0];
        cw[2]  = s[1];
        cw[4]  = s[2];
        cw[8]  = s[3];
        cw[0]  = ^cw[12:1];
        return cw;
    endfunction

    // Apply one request to the shadow memory and return its outcome
    function automatic verdict_t access_memory(input logic [1:0] req, input logic [9:0] addr,
                                               input logic [7:0] wdata,
                                               input logic [12:0] mask);
        verdict_t    v;
        logic [12:0] cw;
        logic [3:0]  s;
        logic        odd;
        v  = '{data: 8'd0, status: STAT_OK, pos: 4'd0};
        cw = codeword_mem[addr];
        case (req)
            REQ_WRITE:
                codeword_mem[addr] = build_codeword(wdata);
            REQ_READ:
            begin
                s      = syndrome_of(cw);
                odd    = ^cw;
                v.data = {cw[12:9], cw[7:5], cw[3]};
                if (s == 4'd0)
                begin
                    if (odd)
                    begin
                        v.status = STAT_PARITY;
                        codeword_mem[addr][0] = ^cw[12:1];
                    end
                end
                else if (!odd || s > 4'd12)
                    v.status = STAT_DOUBLE;
                else
                begin
                    v.status = STAT_SINGLE;
                    v.pos    = s;
                end
            end
            REQ_INJECT:
                codeword_mem[addr] = cw ^ mask;
            default:
                ;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // Mostly short gaps, a few long ones; none at all in burst stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [9:0] pick_addr();
        if ($urandom_range(0, 3) != 0)
            return hot_addrs[$urandom_range(0, 7)];
        return 10'($urandom_range(0, DEPTH - 1));
    endfunction

    // None, single, double, up to triple or arbitrary upsets
    function automatic logic [12:0] pick_mask();
        int kind;
        int a;
        int b;
        kind = $urandom_range(0, 9);
        a    = $urandom_range(0, 12);
        b    = (a + $urandom_range(1, 12)) % 13;
        case (kind)
            0:       return 13'd0;
            1, 2, 3, 4: return 13'(1 << a);
            5, 6:    return 13'((1 << a) | (1 << b));
            7:       return 13'((1 << a) | (1 << b) | (1 << $urandom_range(0, 12)));
            default: return 13'($urandom_range(0, 8191));
        endcase
    endfunction

    // Present one request, hold it until taken, and record its outcome
    task automatic issue(input logic [1:0] req, input logic [9:0] addr, input logic [7:0] wdata,
                         input logic [12:0] mask, input logic typed, input verdict_t want);
        int       gap;
        verdict_t pred;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start      <= 1'b1;
        req_type   <= req;
        address    <= addr;
        write_data <= wdata;
        flip_mask  <= mask;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pred = access_memory(req, addr, wdata, mask);
        pending_verdicts.push_back(typed ? want : pred);
        issued++;
    endtask

    // Hold off new requests until every outcome is back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Compare each strobed result with the oldest pending outcome
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch("unrequested result status", status, 0);
            else
            begin
                want = pending_verdicts.pop_front();
                if (read_data !== want.data)
                    report_mismatch("read_data", read_data, want.data);
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (error_position !== want.pos)
                    report_mismatch("error_position", error_position, want.pos);
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        int idle_cycles;
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_secded_hamming_ecc_memory_core: done, errors");
            $finish;
        end
    end

    initial
    begin
        access_row_t r;
        verdict_t    want;
        logic [9:0]  a;
        int          i;
        rst_n      = 1'b0;
        start      = 1'b0;
        req_type   = REQ_WRITE;
        address    = 10'd0;
        write_data = 8'd0;
        flip_mask  = 13'd0;
        for (i = 0; i < DEPTH; i++)
            codeword_mem[i] = 13'd0;
        hot_addrs = '{10'd0, 10'd1023, 10'd1, 10'd512, 10'h155, 10'h2AA,
                      10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023))};

        // Directed: after-reset reads, extremes, every status, unused request code
        directed_rows = '{
            '{REQ_READ,   10'd0,    8'h00, 13'h0000, 1'b1, 8'h00, STAT_OK,     4'd0},
            '{REQ_READ,   10'd1023, 8'h00, 13'h0000, 1'b1, 8'h00, STAT_OK,     4'd0},
            '{REQ_WRITE,  10'd1023, 8'hFF, 13'h0000, 1'b1, 8'h00, STAT_OK,     4'd0},
            '{REQ_READ,   10'd1023, 8'h00, 13'h1FFF, 1'b1, 8'hFF, STAT_OK,     4'd0},
            '{REQ_WRITE,  10'd0,    8'h00, 13'h1FFF, 1'b1, 8'h00, STAT_OK,     4'd0},
            '{REQ_INJECT, 10'd0,    8'hFF, 13'h0001, 1'b1, 8'h00, STAT_OK,     4'd0},
            '{REQ_READ,   10'd0,    8'h00, 13'h0000, 1'b1, 8'h00, STAT_PARITY, 4'd0},
            '{REQ_READ,   10'd0,    8'h00, 13'h0000, 1'b1, 8'h00, STAT_OK,     4'd0},
            '{REQ_INJECT, 10'd0,    8'h00, 13'h1000, 1'b1, 8'h00, STAT_OK,     4'd0},
            '{REQ_READ,   10'd0,    8'h00, 13'h0000, 1'b1, 8'h80, STAT_SINGLE, 4'd12},
            '{REQ_INJECT, 10'd0,    8'h00, 13'h1000, 1'b1, 8'h00, STAT_OK,     4'd0},
            '{REQ_INJECT, 10'd0,    8'h00, 13'h0006, 1'b1, 8'h00, STAT_OK,     4'd0},
            '{REQ_READ,   10'd0,    8'h00, 13'h0000, 1'b1, 8'h00, STAT_DOUBLE, 4'd0},
            '{REQ_INJECT, 10'd0,    8'h00, 13'h0006, 1'b1, 8'h00, STAT_OK,     4'd0},
            '{REQ_INJECT, 10'd0,    8'h00, 13'h0112, 1'b1, 8'h00, STAT_OK,     4'd0},
            '{REQ_READ,   10'd0,    8'h00, 13'h0000, 1'b1, 8'h00, STAT_DOUBLE, 4'd0},
            '{REQ_INJECT, 10'd0,    8'h00, 13'h0112, 1'b1, 8'h00, STAT_OK,     4'd0},
            '{REQ_INJECT, 10'd0,    8'h00, 13'h1FFF, 1'b0, 8'h00, STAT_OK,     4'd0},
            '{REQ_READ,   10'd0,    8'h00, 13'h0000, 1'b0, 8'h00, STAT_OK,     4'd0},
            '{REQ_WRITE,  10'h2AA,  8'hA5, 13'h0000, 1'b0, 8'h00, STAT_OK,     4'd0},
            '{REQ_INJECT, 10'h2AA,  8'h00, 13'h0008, 1'b0, 8'h00, STAT_OK,     4'd0},
            '{REQ_READ,   10'h2AA,  8'h00, 13'h0000, 1'b0, 8'h00, STAT_OK,     4'd0},
            '{REQ_UNUSED, 10'd1023, 8'hFF, 13'h1FFF, 1'b1, 8'h00, STAT_OK,     4'd0},
            '{REQ_READ,   10'd1023, 8'h00, 13'h0000, 1'b1, 8'hFF, STAT_OK,     4'd0},
            '{REQ_INJECT, 10'd1023, 8'h5A, 13'h0A00, 1'b0, 8'h00, STAT_OK,     4'd0},
            '{REQ_READ,   10'd1023, 8'h00, 13'h0000, 1'b0, 8'h00, STAT_OK,     4'd0}
        };

        // Hold reset, then release it on a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (i = 0; i < NUM_ROWS; i++)
        begin
            r    = directed_rows[i];
            want = '{data: r.exp_data, status: status_t'(r.exp_status), pos: r.exp_pos};
            issue(r.req, r.addr, r.wdata, r.mask, r.typed, want);
        end
        drain();

        // Random: mostly write/upset/read sequences on one location, plus single requests
        want = '{data: 8'd0, status: STAT_OK, pos: 4'd0};
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            if ((issued % 64) < 4 && $urandom_range(0, 3) == 0)
                burst_mode = ~burst_mode;
            if (issued >= RANDOM_ITEMS / 2 && issued < RANDOM_ITEMS / 2 + 6)
                drain();
            a = pick_addr();
            if ($urandom_range(0, 99) < 60)
            begin
                if ($urandom_range(0, 4) != 0)
                    issue(REQ_WRITE, a, 8'($urandom), pick_mask(), 1'b0, want);
                issue(REQ_INJECT, a, 8'($urandom), pick_mask(), 1'b0, want);
                if ($urandom_range(0, 2) == 0)
                    issue(REQ_INJECT, a, 8'($urandom), pick_mask(), 1'b0, want);
                issue(REQ_READ, a, 8'($urandom), pick_mask(), 1'b0, want);
                if ($urandom_range(0, 4) == 0)
                    issue(REQ_READ, a, 8'($urandom), pick_mask(), 1'b0, want);
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0:                   issue(REQ_UNUSED, a, 8'($urandom), pick_mask(),
                                               1'b0, want);
                    1, 2, 3, 4, 5, 6:    issue(REQ_WRITE, a, 8'($urandom), pick_mask(),
                                               1'b0, want);
                    7, 8, 9, 10, 11:     issue(REQ_INJECT, a, 8'($urandom), pick_mask(),
                                               1'b0, want);
                    default:             issue(REQ_READ, a, 8'($urandom), pick_mask(),
                                               1'b0, want);
                endcase
            end
        end

        // Let the pipeline empty, then give the verdict
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb_secded_hamming_ecc_memory_core: done, clean");
        else
            $display("tb_secded_hamming_ecc_memory_core: done, errors");
        $finish;
    end

endmodule
